### design/inverse_lfnst_matvec_macros.svh
// Assertion macros shared by the inverse LFNST matrix-vector engine.
`ifndef INVERSE_LFNST_MATVEC_MACROS_SVH
`define INVERSE_LFNST_MATVEC_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ILFNST_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("inverse_lfnst_matvec assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ILFNST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("inverse_lfnst_matvec assertion failed");

`else

`define ILFNST_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ILFNST_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### design/ilfnst_pkg.sv
// Types, constants and codes shared by the inverse LFNST matrix-vector engine.
`timescale 1ns / 1ps

package ilfnst_pkg;

    localparam int KERNEL_DEPTH = 32768;
    localparam int MAX_OUTPUTS  = 48;
    localparam int MAX_INPUTS   = 16;

    localparam int KAW    = $clog2(KERNEL_DEPTH);
    localparam int ROW_W  = $clog2(MAX_OUTPUTS);
    localparam int COL_W  = $clog2(MAX_INPUTS);
    localparam int FULL_W = (KAW > 15) ? KAW : 15;

    localparam int N_OUT_LARGE = (MAX_OUTPUTS < 48) ? MAX_OUTPUTS : 48;
    localparam int N_OUT_SMALL = (MAX_OUTPUTS < 16) ? MAX_OUTPUTS : 16;
    localparam int N_IN_WIDE   = (MAX_INPUTS < 16) ? MAX_INPUTS : 16;
    localparam int N_IN_NARROW = (MAX_INPUTS < 8) ? MAX_INPUTS : 8;

    localparam int KVAL_W = 8;
    localparam int SRC_W  = 16;
    localparam int PROD_W = KVAL_W + SRC_W;
    localparam int ACC_W  = PROD_W + COL_W;
    localparam int RND_W  = ACC_W + 1;
    localparam int OUT_W  = 16;

    localparam int RND_ADD   = 64;
    localparam int RND_SHIFT = 7;
    localparam logic signed [RND_W-1:0] CLIP_HI = RND_W'((1 << 15) - 1);
    localparam logic signed [RND_W-1:0] CLIP_LO = RND_W'(-(1 << 15));

    localparam logic [1:0] KIDX_INVALID = 2'd3;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_LOAD  = 2'd1,
        FUNC_RUN   = 2'd2
    } func_t;

    typedef struct packed {
        func_t                    func;
        logic [14:0]              table_address;
        logic signed [KVAL_W-1:0] table_value;
        logic [3:0]               coeff_index;
        logic signed [SRC_W-1:0]  coeff_value;
        logic                     large_block;
        logic                     wide_input;
        logic [1:0]               mode_sel;
        logic [1:0]               kernel_index;
    } request_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] out_value;
        logic [5:0]              out_position;
        logic                    last;
        logic                    bad_request;
    } result_t;

    typedef struct packed {
        logic                     wr_en;
        logic [KAW-1:0]           wr_addr;
        logic signed [KVAL_W-1:0] wr_data;
        logic                     ld_en;
        logic [COL_W-1:0]         ld_idx;
        logic signed [SRC_W-1:0]  ld_data;
        logic                     rd_en;
        logic [KAW-1:0]           rd_addr;
        logic [COL_W-1:0]         col;
        logic                     first;
        logic                     last_col;
        logic [ROW_W-1:0]         row;
        logic                     last_row;
        logic                     err;
    } cmd_t;

    typedef struct packed {
        logic done;
    } status_t;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last_col;
        logic [ROW_W-1:0] row;
        logic             last_row;
    } tag_t;

endpackage

### design/ilfnst_ctrl.sv
// Controller state machine that sequences writes, loads and kernel reads of a run.
`timescale 1ns / 1ps

module ilfnst_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  ilfnst_pkg::request_t request,
    input  ilfnst_pkg::status_t status,
    output ilfnst_pkg::cmd_t    cmd,
    output logic                busy
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t                        state_reg, state_next;
    logic [ilfnst_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [ilfnst_pkg::COL_W-1:0]  col_reg, col_next;
    logic [ilfnst_pkg::ROW_W-1:0]  row_last_reg, row_last_next;
    logic [ilfnst_pkg::COL_W-1:0]  col_last_reg, col_last_next;
    logic                          large_reg, large_next;
    logic [1:0]                    mode_reg, mode_next;
    logic [1:0]                    kidx_reg, kidx_next;
    logic                          accept;
    logic                          at_last_col;
    logic                          at_last_row;
    logic [ilfnst_pkg::FULL_W-1:0] wr_full;
    logic [ilfnst_pkg::FULL_W-1:0] rd_full;

    assign accept      = start && (state_reg == ST_IDLE);
    assign busy        = (state_reg != ST_IDLE);
    assign at_last_col = (col_reg == col_last_reg);
    assign at_last_row = (row_reg == row_last_reg);

    assign wr_full = ilfnst_pkg::FULL_W'(request.table_address);
    assign rd_full = ilfnst_pkg::FULL_W'({large_reg, mode_reg, kidx_reg, 10'b0})
                   | (ilfnst_pkg::FULL_W'(row_reg) << 4)
                   | ilfnst_pkg::FULL_W'(col_reg);

    always_comb
    begin
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        row_last_next = row_last_reg;
        col_last_next = col_last_reg;
        large_next    = large_reg;
        mode_next     = mode_reg;
        kidx_next     = kidx_reg;

        cmd          = '0;
        cmd.wr_addr  = wr_full[ilfnst_pkg::KAW-1:0];
        cmd.wr_data  = request.table_value;
        cmd.ld_idx   = request.coeff_index[ilfnst_pkg::COL_W-1:0];
        cmd.ld_data  = request.coeff_value;
        cmd.rd_addr  = rd_full[ilfnst_pkg::KAW-1:0];
        cmd.col      = col_reg;
        cmd.row      = row_reg;
        cmd.first    = (col_reg == '0);
        cmd.last_col = at_last_col;
        cmd.last_row = at_last_row;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (request.func)
                        ilfnst_pkg::FUNC_WRITE:
                        begin
                            cmd.wr_en = 1'b1;
                        end
                        ilfnst_pkg::FUNC_LOAD:
                        begin
                            cmd.ld_en = 1'b1;
                        end
                        ilfnst_pkg::FUNC_RUN:
                        begin
                            if (request.kernel_index == ilfnst_pkg::KIDX_INVALID)
                            begin
                                cmd.err = 1'b1;
                            end
                            else
                            begin
                                large_next    = request.large_block;
                                mode_next     = request.mode_sel;
                                kidx_next     = request.kernel_index;
                                row_next      = '0;
                                col_next      = '0;
                                row_last_next = request.large_block
                                    ? ilfnst_pkg::ROW_W'(ilfnst_pkg::N_OUT_LARGE - 1)
                                    : ilfnst_pkg::ROW_W'(ilfnst_pkg::N_OUT_SMALL - 1);
                                col_last_next = request.wide_input
                                    ? ilfnst_pkg::COL_W'(ilfnst_pkg::N_IN_WIDE - 1)
                                    : ilfnst_pkg::COL_W'(ilfnst_pkg::N_IN_NARROW - 1);
                                state_next    = ST_RUN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                cmd.rd_en = 1'b1;
                if (at_last_col)
                begin
                    col_next = '0;
                    if (at_last_row)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (status.done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        col_reg      <= col_next;
        row_last_reg <= row_last_next;
        col_last_reg <= col_last_next;
        large_reg    <= large_next;
        mode_reg     <= mode_next;
        kidx_reg     <= kidx_next;
    end

endmodule

### design/ilfnst_datapath.sv
// Datapath with the kernel memory, source registers, multiply-accumulate and output stage.
`timescale 1ns / 1ps

module ilfnst_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ilfnst_pkg::cmd_t     cmd,
    output ilfnst_pkg::status_t  status,
    output ilfnst_pkg::result_t  result,
    output logic                 valid
);

    logic signed [ilfnst_pkg::KVAL_W-1:0] kernel_mem [ilfnst_pkg::KERNEL_DEPTH];
    logic signed [ilfnst_pkg::SRC_W-1:0]  src_mem [ilfnst_pkg::MAX_INPUTS];

    logic signed [ilfnst_pkg::KVAL_W-1:0] kdata_reg;
    logic signed [ilfnst_pkg::SRC_W-1:0]  src1_reg;
    logic signed [ilfnst_pkg::PROD_W-1:0] prod_reg;
    logic signed [ilfnst_pkg::ACC_W-1:0]  acc_reg, acc_next;
    ilfnst_pkg::tag_t                     tag1_reg, tag2_reg, tag3_reg;
    ilfnst_pkg::tag_t                     tag1_next;

    logic signed [ilfnst_pkg::RND_W-1:0]  rounded;
    logic signed [ilfnst_pkg::RND_W-1:0]  shifted;
    logic signed [ilfnst_pkg::RND_W-1:0]  clipped;

    ilfnst_pkg::result_t                  result_reg, result_next;
    logic                                 valid_reg, valid_next;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            kernel_mem[cmd.wr_addr] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            kdata_reg <= kernel_mem[cmd.rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_en)
        begin
            src_mem[cmd.ld_idx] <= cmd.ld_data;
        end
        src1_reg <= src_mem[cmd.col];
    end

    always_comb
    begin
        tag1_next          = '0;
        tag1_next.valid    = cmd.rd_en;
        tag1_next.first    = cmd.first;
        tag1_next.last_col = cmd.last_col;
        tag1_next.row      = cmd.row;
        tag1_next.last_row = cmd.last_row;
    end

    assign acc_next = tag2_reg.first
                    ? ilfnst_pkg::ACC_W'(prod_reg)
                    : acc_reg + ilfnst_pkg::ACC_W'(prod_reg);

    always_ff @(posedge clk)
    begin
        prod_reg <= src1_reg * kdata_reg;
        if (tag2_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    assign rounded = ilfnst_pkg::RND_W'(acc_reg) + ilfnst_pkg::RND_W'(ilfnst_pkg::RND_ADD);
    assign shifted = rounded >>> ilfnst_pkg::RND_SHIFT;

    always_comb
    begin
        if (shifted > ilfnst_pkg::CLIP_HI)
        begin
            clipped = ilfnst_pkg::CLIP_HI;
        end
        else if (shifted < ilfnst_pkg::CLIP_LO)
        begin
            clipped = ilfnst_pkg::CLIP_LO;
        end
        else
        begin
            clipped = shifted;
        end
    end

    always_comb
    begin
        result_next = result_reg;
        valid_next  = 1'b0;
        if (cmd.err)
        begin
            valid_next               = 1'b1;
            result_next.out_value    = '0;
            result_next.out_position = '0;
            result_next.last         = 1'b1;
            result_next.bad_request  = 1'b1;
        end
        else if (tag3_reg.valid && tag3_reg.last_col)
        begin
            valid_next               = 1'b1;
            result_next.out_value    = clipped[ilfnst_pkg::OUT_W-1:0];
            result_next.out_position = 6'(tag3_reg.row);
            result_next.last         = tag3_reg.last_row;
            result_next.bad_request  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg  <= '0;
            tag2_reg  <= '0;
            tag3_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            tag1_reg  <= tag1_next;
            tag2_reg  <= tag1_reg;
            tag3_reg  <= tag2_reg;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result      = result_reg;
    assign valid       = valid_reg;
    assign status.done = valid_reg && result_reg.last && !result_reg.bad_request;

endmodule

### design/inverse_lfnst_matvec.sv
// Top level of the inverse LFNST matrix-vector engine.
`timescale 1ns / 1ps
// A transaction is taken when start is high and busy is low. Write and load
// transactions complete in the cycle they are taken and leave busy low. A
// run reads one kernel entry from the kernel memory and performs one
// multiply-accumulate per cycle over n_out * n_in entries, with n_out 16 or
// 48 and n_in 8 or 16, keeps busy high until its last result is out, and
// delivers one result per output after its n_in products. A run with an
// invalid kernel index yields its single error result in the next cycle and
// leaves busy low. Each result is shown for exactly one cycle with valid high;
// the receiver cannot stall the block and must take every result as it appears.

`include "inverse_lfnst_matvec_macros.svh"

module inverse_lfnst_matvec
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  ilfnst_pkg::request_t request,
    output logic                 busy,
    output ilfnst_pkg::result_t  result,
    output logic                 valid
);

    ilfnst_pkg::cmd_t    cmd;
    ilfnst_pkg::status_t status;

    ilfnst_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .status  (status),
        .cmd     (cmd),
        .busy    (busy)
    );

    ilfnst_datapath u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status),
        .result (result),
        .valid  (valid)
    );

    `ILFNST_ASSERT_NEXT(a_idle_after_final, clk, rst_n, valid && result.last && !result.bad_request, !busy)
    `ILFNST_ASSERT_SAME(a_partial_while_busy, clk, rst_n, valid && !result.last, busy)
    `ILFNST_ASSERT_NEXT(a_error_result, clk, rst_n, start && !busy && (request.func == ilfnst_pkg::FUNC_RUN) && (request.kernel_index == ilfnst_pkg::KIDX_INVALID), valid && result.bad_request && result.last)

endmodule
